// ===== hdl/yprht_pkg.sv =====
`timescale 1ns / 1ps
package yprht_pkg;

    localparam int TRIG_W          = 32;
    localparam int SHIFT_W         = 32;
    localparam int ENTRY_CNT       = 9;
    localparam int MERGE_STAGES    = 5;
    localparam int DEF_ANGLE_BITS  = 16;
    localparam int DEF_ENTRY_BITS  = 16;
    localparam int DEF_TRIG_STAGES = 16;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [31:0] ATAN_TURN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef logic signed [TRIG_W-1:0]  t_trig;
    typedef logic signed [SHIFT_W-1:0] t_shift;
    typedef logic signed [63:0]        t_prod;

    typedef struct packed {
        t_trig c;
        t_trig s;
    } t_sincos;

endpackage

// ===== hdl/yprht_pose_if.sv =====
`timescale 1ns / 1ps
interface yprht_pose_if #(
    parameter int ANGLE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [31:0]           shift_x_in;
    logic signed [31:0]           shift_y_in;
    logic signed [31:0]           shift_z_in;

    modport source (
        output valid, yaw_angle, pitch_angle, roll_angle,
               shift_x_in, shift_y_in, shift_z_in,
        input  ready
    );
    modport sink (
        input  valid, yaw_angle, pitch_angle, roll_angle,
               shift_x_in, shift_y_in, shift_z_in,
        output ready
    );
endinterface

// ===== hdl/yprht_frame_if.sv =====
`timescale 1ns / 1ps
interface yprht_frame_if #(
    parameter int ENTRY_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [ENTRY_BITS-1:0] m00;
    logic signed [ENTRY_BITS-1:0] m01;
    logic signed [ENTRY_BITS-1:0] m02;
    logic signed [ENTRY_BITS-1:0] m10;
    logic signed [ENTRY_BITS-1:0] m11;
    logic signed [ENTRY_BITS-1:0] m12;
    logic signed [ENTRY_BITS-1:0] m20;
    logic signed [ENTRY_BITS-1:0] m21;
    logic signed [ENTRY_BITS-1:0] m22;
    logic signed [31:0]           shift_x_out;
    logic signed [31:0]           shift_y_out;
    logic signed [31:0]           shift_z_out;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
               shift_x_out, shift_y_out, shift_z_out,
        input  ready
    );
    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
               shift_x_out, shift_y_out, shift_z_out,
        output ready
    );
endinterface

// ===== hdl/yprht_cordic.sv =====
`timescale 1ns / 1ps
module yprht_cordic
    import yprht_pkg::*;
#(
    parameter int ANGLE_BITS  = DEF_ANGLE_BITS,
    parameter int TRIG_STAGES = DEF_TRIG_STAGES
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output t_sincos               o_sc
);

    localparam int XW = 34;
    localparam int ZW = 33;

    logic [31:0]        w_u;
    logic               w_flip;
    logic signed [31:0] w_zf;
    logic signed [XW-1:0] w_nx;
    logic signed [XW-1:0] w_ny;

    logic signed [XW-1:0] x_s [TRIG_STAGES+1];
    logic signed [XW-1:0] y_s [TRIG_STAGES+1];
    logic signed [ZW-1:0] z_s [TRIG_STAGES+1];
    logic                 f_s [TRIG_STAGES+1];

    // fold into [-1/4, 1/4) turn
    assign w_u    = 32'(i_angle) << (32 - ANGLE_BITS);
    assign w_flip = w_u[31] ^ w_u[30];
    assign w_zf   = {w_u[31] ^ w_flip, w_u[30:0]};

    assign x_s[0] = CORDIC_X0;
    assign y_s[0] = '0;
    assign z_s[0] = ZW'(w_zf);
    assign f_s[0] = w_flip;

    for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
        logic signed [XW-1:0] n_x;
        logic signed [XW-1:0] n_y;
        logic signed [ZW-1:0] n_z;
        logic signed [ZW-1:0] w_atn;
        logic signed [XW-1:0] r_x;
        logic signed [XW-1:0] r_y;
        logic signed [ZW-1:0] r_z;
        logic                 r_f;

        assign w_atn = ZW'({1'b0, ATAN_TURN[i]});

        always_comb begin
            if (!z_s[i][ZW-1]) begin
                n_x = x_s[i] - (y_s[i] >>> i);
                n_y = y_s[i] + (x_s[i] >>> i);
                n_z = z_s[i] - w_atn;
            end else begin
                n_x = x_s[i] + (y_s[i] >>> i);
                n_y = y_s[i] - (x_s[i] >>> i);
                n_z = z_s[i] + w_atn;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_f <= f_s[i];
            end
        end

        assign x_s[i+1] = r_x;
        assign y_s[i+1] = r_y;
        assign z_s[i+1] = r_z;
        assign f_s[i+1] = r_f;
    end

    assign w_nx = -x_s[TRIG_STAGES];
    assign w_ny = -y_s[TRIG_STAGES];

    assign o_sc.c = f_s[TRIG_STAGES] ? w_nx[TRIG_W-1:0] : x_s[TRIG_STAGES][TRIG_W-1:0];
    assign o_sc.s = f_s[TRIG_STAGES] ? w_ny[TRIG_W-1:0] : y_s[TRIG_STAGES][TRIG_W-1:0];

endmodule

// ===== hdl/yprht_merge.sv =====
`timescale 1ns / 1ps
module yprht_merge
    import yprht_pkg::*;
#(
    parameter int ENTRY_BITS = DEF_ENTRY_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  t_sincos                      i_yaw,
    input  t_sincos                      i_pitch,
    input  t_sincos                      i_roll,
    output logic signed [ENTRY_BITS-1:0] o_m [ENTRY_CNT]
);

    localparam int SH = 62 - ENTRY_BITS;
    localparam logic signed [64:0] RND = 65'sd1 <<< (SH - 1);
    localparam logic signed [64:0] HI  = (65'sd1 <<< (ENTRY_BITS - 1)) - 65'sd1;
    localparam logic signed [64:0] LO  = -HI - 65'sd1;
    localparam t_prod HALF_Q30 = 64'sd536870912;

    t_prod r1_p [10];
    t_trig r1_sp, r1_sr, r1_cr;

    t_prod r2_p [8];
    t_trig r2_cysp, r2_sysp, r2_sp, r2_sr, r2_cr;

    t_prod r3_p [8];
    t_prod r3_t [4];
    t_trig r3_sp;

    t_prod r4_e [ENTRY_CNT];

    logic signed [64:0] w_r [ENTRY_CNT];

    // pairwise products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p[0] <= i_yaw.c   * i_pitch.c;
            r1_p[1] <= i_yaw.s   * i_pitch.c;
            r1_p[2] <= i_pitch.c * i_roll.s;
            r1_p[3] <= i_pitch.c * i_roll.c;
            r1_p[4] <= i_yaw.s   * i_roll.c;
            r1_p[5] <= i_yaw.s   * i_roll.s;
            r1_p[6] <= i_yaw.c   * i_roll.c;
            r1_p[7] <= i_yaw.c   * i_roll.s;
            r1_p[8] <= i_yaw.c   * i_pitch.s;
            r1_p[9] <= i_yaw.s   * i_pitch.s;
            r1_sp   <= i_pitch.s;
            r1_sr   <= i_roll.s;
            r1_cr   <= i_roll.c;
        end
    end

    // round cy*sp and sy*sp back to Q30
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 8; k++) begin
                r2_p[k] <= r1_p[k];
            end
            r2_cysp <= t_trig'((r1_p[8] + HALF_Q30) >>> 30);
            r2_sysp <= t_trig'((r1_p[9] + HALF_Q30) >>> 30);
            r2_sp   <= r1_sp;
            r2_sr   <= r1_sr;
            r2_cr   <= r1_cr;
        end
    end

    // triple products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p    <= r2_p;
            r3_t[0] <= r2_cysp * r2_sr;
            r3_t[1] <= r2_cysp * r2_cr;
            r3_t[2] <= r2_sysp * r2_sr;
            r3_t[3] <= r2_sysp * r2_cr;
            r3_sp   <= r2_sp;
        end
    end

    // combine into Q60 entries
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_e[0] <= r3_p[0];
            r4_e[1] <= r3_t[0] - r3_p[4];
            r4_e[2] <= r3_t[1] + r3_p[5];
            r4_e[3] <= r3_p[1];
            r4_e[4] <= r3_t[2] + r3_p[6];
            r4_e[5] <= r3_t[3] - r3_p[7];
            r4_e[6] <= -(t_prod'(r3_sp) <<< 30);
            r4_e[7] <= r3_p[2];
            r4_e[8] <= r3_p[3];
        end
    end

    always_comb begin
        for (int k = 0; k < ENTRY_CNT; k++) begin
            w_r[k] = (65'(r4_e[k]) + RND) >>> SH;
        end
    end

    // round half up and saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ENTRY_CNT; k++) begin
                if (w_r[k] > HI) begin
                    o_m[k] <= HI[ENTRY_BITS-1:0];
                end else if (w_r[k] < LO) begin
                    o_m[k] <= LO[ENTRY_BITS-1:0];
                end else begin
                    o_m[k] <= w_r[k][ENTRY_BITS-1:0];
                end
            end
        end
    end

endmodule

// ===== hdl/ypr_to_homogeneous_transform.sv =====
`timescale 1ns / 1ps
// Yaw-pitch-roll to the upper three rows of a homogeneous transform.
// i_pose (sink) carries three binary angles, one turn = 2^ANGLE_BITS, and
// a Q16.16 translation. o_frame (source) carries the Z-Y-X rotation
// matrix in signed Q2.14 (ENTRY_BITS-2 fraction bits) and the
// translation, unchanged. A word moves when valid and ready are high.
// From accept to o_frame.valid a word passes through the three CORDIC
// lanes and then the pairwise-product, Q30-rounding, triple-product,
// combine and round-and-saturate stages; every stage is a register slice.
// Throughput: one word per cycle while the skid register is empty.
// When o_frame.ready is low, the finished word moves into a skid register
// and the pipeline keeps accepting for that cycle; i_pose.ready then drops
// until the skid register empties, and every stage holds.
// Reset clears all valid flags, the skid flag among them; words in flight
// are dropped. Each input word gives exactly one output word.
module ypr_to_homogeneous_transform
    import yprht_pkg::*;
#(
    parameter int ANGLE_BITS  = DEF_ANGLE_BITS,
    parameter int ENTRY_BITS  = DEF_ENTRY_BITS,
    parameter int TRIG_STAGES = DEF_TRIG_STAGES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    yprht_pose_if.sink    i_pose,
    yprht_frame_if.source o_frame
);

    localparam int LAT = TRIG_STAGES + MERGE_STAGES;

    logic    w_en;
    t_sincos w_yaw, w_pitch, w_roll;
    logic signed [ENTRY_BITS-1:0] w_m [ENTRY_CNT];

    logic [LAT-1:0] r_v;
    t_shift         r_sx [LAT];
    t_shift         r_sy [LAT];
    t_shift         r_sz [LAT];

    logic                         r_skid_v;
    logic                         n_skid_v;
    logic signed [ENTRY_BITS-1:0] r_sk_m [ENTRY_CNT];
    t_shift                       r_sk_sx, r_sk_sy, r_sk_sz;

    assign w_en         = !r_skid_v;
    assign i_pose.ready = w_en;

    yprht_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_pose.yaw_angle),
        .o_sc    (w_yaw)
    );

    yprht_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_pose.pitch_angle),
        .o_sc    (w_pitch)
    );

    yprht_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_pose.roll_angle),
        .o_sc    (w_roll)
    );

    yprht_merge #(.ENTRY_BITS(ENTRY_BITS)) u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_yaw   (w_yaw),
        .i_pitch (w_pitch),
        .i_roll  (w_roll),
        .o_m     (w_m)
    );

    // translation rides alongside the lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx[0] <= i_pose.shift_x_in;
            r_sy[0] <= i_pose.shift_y_in;
            r_sz[0] <= i_pose.shift_z_in;
            for (int k = 1; k < LAT; k++) begin
                r_sx[k] <= r_sx[k-1];
                r_sy[k] <= r_sy[k-1];
                r_sz[k] <= r_sz[k-1];
            end
        end
    end

    always_comb begin
        if (r_skid_v) begin
            n_skid_v = !o_frame.ready;
        end else begin
            n_skid_v = r_v[LAT-1] && !o_frame.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_v <= {r_v[LAT-2:0], i_pose.valid};
            end
            r_skid_v <= n_skid_v;
        end
    end

    // capture the stalled word
    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_sk_m  <= w_m;
            r_sk_sx <= r_sx[LAT-1];
            r_sk_sy <= r_sy[LAT-1];
            r_sk_sz <= r_sz[LAT-1];
        end
    end

    assign o_frame.valid       = r_skid_v || r_v[LAT-1];
    assign o_frame.m00         = r_skid_v ? r_sk_m[0] : w_m[0];
    assign o_frame.m01         = r_skid_v ? r_sk_m[1] : w_m[1];
    assign o_frame.m02         = r_skid_v ? r_sk_m[2] : w_m[2];
    assign o_frame.m10         = r_skid_v ? r_sk_m[3] : w_m[3];
    assign o_frame.m11         = r_skid_v ? r_sk_m[4] : w_m[4];
    assign o_frame.m12         = r_skid_v ? r_sk_m[5] : w_m[5];
    assign o_frame.m20         = r_skid_v ? r_sk_m[6] : w_m[6];
    assign o_frame.m21         = r_skid_v ? r_sk_m[7] : w_m[7];
    assign o_frame.m22         = r_skid_v ? r_sk_m[8] : w_m[8];
    assign o_frame.shift_x_out = r_skid_v ? r_sk_sx : r_sx[LAT-1];
    assign o_frame.shift_y_out = r_skid_v ? r_sk_sy : r_sy[LAT-1];
    assign o_frame.shift_z_out = r_skid_v ? r_sk_sz : r_sz[LAT-1];

    a_skid_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_pose.ready)
        else $error("input accepted while skid register full");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !o_frame.ready |=> r_skid_v)
        else $error("skid word lost under stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pose.valid && i_pose.ready |=> r_v[0])
        else $error("accepted word missing from first stage");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_v) || !$past(r_skid_v))
        else $error("pipeline advanced while skid register full");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_frame.valid)
        else $error("output valid right after reset");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import yprht_pkg::*;

    localparam int AB = DEF_ANGLE_BITS;
    localparam int EB = DEF_ENTRY_BITS;
    localparam int NS = DEF_TRIG_STAGES;
    localparam int LATENCY = NS + 5;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
    } t_pose;

    typedef struct {
        logic signed [15:0] m [9];
        logic signed [31:0] sh [3];
    } t_frame;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    yprht_pose_if #(.ANGLE_BITS(AB)) pose_bus ();
    yprht_frame_if #(.ENTRY_BITS(EB)) frame_bus ();

    ypr_to_homogeneous_transform #(
        .ANGLE_BITS(AB), .ENTRY_BITS(EB), .TRIG_STAGES(NS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_pose(pose_bus.sink),
        .o_frame(frame_bus.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_frame frames_due [$];
    int     mismatches = 0;
    int     words_sent = 0;
    int     words_seen = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_recv = 1'b0;
    bit     timed_out = 1'b0;

    initial begin
        pose_bus.valid = 1'b0;
        pose_bus.yaw_angle = '0;
        pose_bus.pitch_angle = '0;
        pose_bus.roll_angle = '0;
        pose_bus.shift_x_in = '0;
        pose_bus.shift_y_in = '0;
        pose_bus.shift_z_in = '0;
        frame_bus.ready = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cordic_sincos(logic [15:0] ang, output longint c,
                                          output longint s);
        logic [31:0] u;
        bit          flip;
        longint      x, y, z, nx, ny;
        u = {ang, 16'd0};
        flip = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
        if (flip) u = u + 32'h8000_0000;
        z = longint'($signed(u));
        x = 652032874;
        y = 0;
        for (int i = 0; i < NS; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z = z - longint'(ATAN_TURN[i]);
            end else begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z = z + longint'(ATAN_TURN[i]);
            end
            x = nx;
            y = ny;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [15:0] q60_to_entry(longint v);
        int     sh;
        longint r, hi;
        sh = 62 - EB;
        r = floor_shift(v + (longint'(1) <<< (sh - 1)), sh);
        hi = (longint'(1) <<< (EB - 1)) - 1;
        if (r > hi) r = hi;
        if (r < -hi - 1) r = -hi - 1;
        return r[15:0];
    endfunction

    function automatic t_frame pose_to_frame(t_pose p);
        t_frame f;
        longint cy, sy, cp, sp, cr, sr, cysp, sysp;
        cordic_sincos(p.yaw, cy, sy);
        cordic_sincos(p.pitch, cp, sp);
        cordic_sincos(p.roll, cr, sr);
        cysp = floor_shift(cy * sp + (longint'(1) <<< 29), 30);
        sysp = floor_shift(sy * sp + (longint'(1) <<< 29), 30);
        f.m[0] = q60_to_entry(cy * cp);
        f.m[1] = q60_to_entry(cysp * sr - sy * cr);
        f.m[2] = q60_to_entry(cysp * cr + sy * sr);
        f.m[3] = q60_to_entry(sy * cp);
        f.m[4] = q60_to_entry(sysp * sr + cy * cr);
        f.m[5] = q60_to_entry(sysp * cr - cy * sr);
        f.m[6] = q60_to_entry(-sp * (longint'(1) <<< 30));
        f.m[7] = q60_to_entry(cp * sr);
        f.m[8] = q60_to_entry(cp * cr);
        f.sh[0] = p.sx;
        f.sh[1] = p.sy;
        f.sh[2] = p.sz;
        return f;
    endfunction

    task automatic send_pose(t_pose p);
        while ($urandom_range(99) < send_idle_pct) begin
            pose_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pose_bus.valid <= 1'b1;
        pose_bus.yaw_angle <= p.yaw;
        pose_bus.pitch_angle <= p.pitch;
        pose_bus.roll_angle <= p.roll;
        pose_bus.shift_x_in <= p.sx;
        pose_bus.shift_y_in <= p.sy;
        pose_bus.shift_z_in <= p.sz;
        do @(posedge i_clk); while (!pose_bus.ready);
        frames_due.push_back(pose_to_frame(p));
        words_sent++;
    endtask

    function automatic t_pose rand_pose();
        t_pose p;
        p.yaw = $urandom;
        p.pitch = $urandom;
        p.roll = $urandom;
        p.sx = $urandom;
        p.sy = $urandom;
        p.sz = $urandom;
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_recv) begin
            frame_bus.ready <= 1'b0;
        end else begin
            frame_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frame exp_f;
        t_frame got;
        bit     bad;
        if (i_rst_n && frame_bus.valid && frame_bus.ready) begin
            words_seen++;
            got.m = '{frame_bus.m00, frame_bus.m01, frame_bus.m02, frame_bus.m10,
                      frame_bus.m11, frame_bus.m12, frame_bus.m20, frame_bus.m21,
                      frame_bus.m22};
            got.sh = '{frame_bus.shift_x_out, frame_bus.shift_y_out,
                       frame_bus.shift_z_out};
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output word");
            end else begin
                exp_f = frames_due.pop_front();
                bad = 1'b0;
                for (int k = 0; k < 9; k++) if (got.m[k] !== exp_f.m[k]) bad = 1'b1;
                for (int k = 0; k < 3; k++) if (got.sh[k] !== exp_f.sh[k]) bad = 1'b1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch word %0d: exp m=%p sh=%p", words_seen,
                                 exp_f.m, exp_f.sh);
                        $display("                 got m=%p sh=%p", got.m, got.sh);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pose_bus.valid && pose_bus.ready)
                || (frame_bus.valid && frame_bus.ready) || hold_recv) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic test_directed();
        t_pose p;
        logic signed [15:0] angs [10] = '{16'sd0, 16'sd16384, -16'sd16384, -16'sd32768,
            16'sd32767, 16'sd8192, -16'sd8192, 16'sd16383, 16'sd1, -16'sd1};
        foreach (angs[k]) begin
            p = '{angs[k], angs[(k + 3) % 10], angs[(k + 7) % 10],
                  32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0};
            send_pose(p);
        end
        p = '{-16'sd32768, -16'sd32768, -16'sd32768, -32'sd1, 32'sd65536, 32'sh5555_AAAA};
        send_pose(p);
        p = '{16'sd32767, 16'sd32767, 16'sd32767, 32'sd0, -32'sd1, 32'shAAAA_5555};
        send_pose(p);
        p = '{16'sd0, 16'sd16384, 16'sd0, 32'sd1, 32'sd1, 32'sd1};
        send_pose(p);
        p = '{16'sd0, -16'sd16384, 16'sd8192, 32'sd2, 32'sd3, 32'sd4};
        send_pose(p);
    endtask

    task automatic test_random(int count);
        repeat (count) send_pose(rand_pose());
    endtask

    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            repeat (60) send_pose(rand_pose());
        join
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(80);
        send_idle_pct = 59; recv_stall_pct = 0;  test_random(80);
        send_idle_pct = 0;  recv_stall_pct = 59; test_random(80);
        send_idle_pct = 33; recv_stall_pct = 33; test_random(80);
        send_idle_pct = 0;  recv_stall_pct = 0;  test_backpressure();
        pose_bus.valid <= 1'b0;
        recv_stall_pct = 20;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY * 3) @(posedge i_clk);
        $display("Covered %0d poses: angle extremes and quadrant edges, random poses",
                 words_sent);
        $display("under sender gaps, receiver stalls and a long output hold-off.");
        if (mismatches == 0 && words_seen == words_sent) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
